@@ design/bpl_pkg.sv @@
// shared widths, operation and status codes for the bounded positional list
`timescale 1ns / 1ps
`default_nettype none

package bpl_pkg;

  localparam int BPL_CAPACITY   = 16;
  localparam int BPL_DATA_WIDTH = 8;

  localparam int BPL_MODE_W   = 3;
  localparam int BPL_POS_W    = 6;
  localparam int BPL_VAL_W    = 8;
  localparam int BPL_STATUS_W = 2;
  localparam int BPL_COUNT_W  = 7;

  localparam int BPL_IN_TDATA_W  = 16;
  localparam int BPL_OUT_TDATA_W = 24;

  typedef logic [BPL_MODE_W-1:0]   bpl_mode_t;
  typedef logic [BPL_STATUS_W-1:0] bpl_status_t;

  localparam bpl_mode_t MODE_PUSH_BACK  = 3'd0;
  localparam bpl_mode_t MODE_PUSH_FRONT = 3'd1;
  localparam bpl_mode_t MODE_INSERT     = 3'd2;
  localparam bpl_mode_t MODE_POP_BACK   = 3'd3;
  localparam bpl_mode_t MODE_POP_FRONT  = 3'd4;
  localparam bpl_mode_t MODE_REMOVE     = 3'd5;
  localparam bpl_mode_t MODE_DUMP       = 3'd6;

  localparam bpl_status_t ST_DONE    = 2'd0;
  localparam bpl_status_t ST_IGNORED = 2'd1;
  localparam bpl_status_t ST_FULL    = 2'd2;

endpackage

`default_nettype wire

@@ design/bounded_positional_list_top.sv @@
// Ordered list of up to CAPACITY words held in one RAM, with positional insert, remove and
// dump. Each request is one operation; every operation returns one result except a dump of a
// non-empty list, which returns one result per entry in list order with tlast on the final one.
// Entries live in a single-port-write RAM, so insert and remove move the tail one word per
// cycle; push back, pop back and rejected or ignored operations move no entries, and a result
// waits in S_RESP while the output is stalled. A dump reads one entry at a time and waits for
// the output register to free before each read. A new request is taken as soon as the list
// logic is idle, even while the previous result still waits in the output register.
`timescale 1ns / 1ps
`default_nettype none

module bounded_positional_list_top #(
  parameter int CAPACITY   = bpl_pkg::BPL_CAPACITY,
  parameter int DATA_WIDTH = bpl_pkg::BPL_DATA_WIDTH
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // position [5:0], value [13:6], zero [15:14]
  input  wire logic [bpl_pkg::BPL_IN_TDATA_W-1:0]    in_tdata,
  // mode [2:0]
  input  wire logic [bpl_pkg::BPL_MODE_W-1:0]        in_tuser,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  // count [6:0], entry_value [14:7], entry_position [20:15], zero [23:21]
  output logic      [bpl_pkg::BPL_OUT_TDATA_W-1:0]   out_tdata,
  // status [1:0]
  output logic      [bpl_pkg::BPL_STATUS_W-1:0]      out_tuser,
  output logic                                       out_tlast
);

  import bpl_pkg::*;

  localparam int ADDR_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int PAD_W  = BPL_OUT_TDATA_W - BPL_COUNT_W - BPL_VAL_W - BPL_POS_W;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SHIFT   = 3'd1;
  localparam logic [2:0] S_DRAIN   = 3'd2;
  localparam logic [2:0] S_FILL    = 3'd3;
  localparam logic [2:0] S_RESP    = 3'd4;
  localparam logic [2:0] S_DUMP_RD = 3'd5;
  localparam logic [2:0] S_DUMP_LD = 3'd6;

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;

  // operation context
  bpl_status_t       status_r, status_nxt;
  logic              ins_r, ins_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ADDR_W-1:0] end_r, end_nxt;
  logic [ADDR_W-1:0] waddr_r, waddr_nxt;
  logic              wpend_r, wpend_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;

  // output register
  bpl_status_t            out_status_r;
  logic [BPL_COUNT_W-1:0] out_count_r;
  logic [BPL_VAL_W-1:0]   out_val_r;
  logic [BPL_POS_W-1:0]   out_pos_r;
  logic                   out_last_r;

  // ram ports
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  // request fields
  bpl_mode_t            in_mode;
  logic [BPL_POS_W-1:0] in_pos;
  logic [BPL_VAL_W-1:0] in_value;
  logic                 in_fire;
  logic                 out_free;

  logic [BPL_VAL_W+DATA_WIDTH-1:0] val_wide_in;
  logic [BPL_VAL_W+DATA_WIDTH-1:0] val_wide_out;
  logic [DATA_WIDTH-1:0]           word_in;
  logic [BPL_VAL_W-1:0]            word_out;

  logic              full, empty, pos_ok;
  logic [CNT_W-1:0]  cnt_m1;
  logic [ADDR_W-1:0] last_addr;
  logic [ADDR_W-1:0] pos_a;
  logic              do_ins, do_rem, do_back;
  logic [ADDR_W-1:0] op_p;

  logic                 ld;
  bpl_status_t          ld_status;
  logic [BPL_VAL_W-1:0] ld_val;
  logic [BPL_POS_W-1:0] ld_pos;
  logic                 ld_last;

  assign in_mode  = in_tuser;
  assign in_pos   = in_tdata[BPL_POS_W-1:0];
  assign in_value = in_tdata[BPL_POS_W+BPL_VAL_W-1:BPL_POS_W];

  assign in_tready = (state_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // widen or narrow between the 8-bit port word and the stored word
  assign val_wide_in  = {{DATA_WIDTH{1'b0}}, in_value};
  assign word_in      = val_wide_in[DATA_WIDTH-1:0];
  assign val_wide_out = {{BPL_VAL_W{1'b0}}, ram_rdata};
  assign word_out     = val_wide_out[BPL_VAL_W-1:0];

  assign full      = (count_r == CNT_W'(CAPACITY));
  assign empty     = (count_r == '0);
  assign pos_ok    = (BPL_COUNT_W'(in_pos) < BPL_COUNT_W'(count_r));
  assign cnt_m1    = count_r - CNT_W'(1);
  assign last_addr = cnt_m1[ADDR_W-1:0];
  assign pos_a     = in_pos[ADDR_W-1:0];

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    status_nxt = status_r;
    ins_nxt    = ins_r;
    ptr_nxt    = ptr_r;
    end_nxt    = end_r;
    waddr_nxt  = waddr_r;
    wpend_nxt  = wpend_r;
    val_nxt    = val_r;
    ram_we     = 1'b0;
    ram_waddr  = waddr_r;
    ram_wdata  = ram_rdata;
    ram_re     = 1'b0;
    ram_raddr  = ptr_r;
    ld         = 1'b0;
    ld_status  = status_r;
    ld_val     = '0;
    ld_pos     = '0;
    ld_last    = 1'b1;
    do_ins     = 1'b0;
    do_rem     = 1'b0;
    do_back    = 1'b0;
    op_p       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          status_nxt = ST_DONE;
          state_nxt  = S_RESP;
          val_nxt    = word_in;
          wpend_nxt  = 1'b0;
          unique case (in_mode)
            MODE_PUSH_BACK: begin
              if (full) status_nxt = ST_FULL;
              else      do_back = 1'b1;
            end
            MODE_PUSH_FRONT: begin
              if (full) status_nxt = ST_FULL;
              else      do_ins = 1'b1;
            end
            MODE_INSERT: begin
              priority if (!pos_ok) begin
                status_nxt = ST_IGNORED;
              end else if (full) begin
                status_nxt = ST_FULL;
              end else if (pos_a == '0) begin
                do_ins = 1'b1;
              end else if (pos_a == last_addr) begin
                // last position appends at the back
                do_back = 1'b1;
              end else begin
                do_ins = 1'b1;
                op_p   = pos_a;
              end
            end
            MODE_POP_BACK: begin
              if (empty) status_nxt = ST_IGNORED;
              else       count_nxt = cnt_m1;
            end
            MODE_POP_FRONT: begin
              if (empty) status_nxt = ST_IGNORED;
              else       do_rem = 1'b1;
            end
            MODE_REMOVE: begin
              if (!pos_ok) begin
                status_nxt = ST_IGNORED;
              end else begin
                do_rem = 1'b1;
                op_p   = pos_a;
              end
            end
            MODE_DUMP: begin
              if (empty) begin
                status_nxt = ST_IGNORED;
              end else begin
                ptr_nxt   = '0;
                end_nxt   = last_addr;
                state_nxt = S_DUMP_RD;
              end
            end
            default: status_nxt = ST_IGNORED;
          endcase

          if (do_back) begin
            ram_we    = 1'b1;
            ram_waddr = count_r[ADDR_W-1:0];
            ram_wdata = word_in;
            count_nxt = count_r + CNT_W'(1);
          end
          if (do_ins) begin
            count_nxt = count_r + CNT_W'(1);
            ins_nxt   = 1'b1;
            end_nxt   = op_p;
            ptr_nxt   = last_addr;
            state_nxt = empty ? S_FILL : S_SHIFT;
          end
          if (do_rem) begin
            count_nxt = cnt_m1;
            ins_nxt   = 1'b0;
            end_nxt   = last_addr;
            ptr_nxt   = op_p + ADDR_W'(1);
            // dropping the final entry moves nothing
            state_nxt = (op_p == last_addr) ? S_RESP : S_SHIFT;
          end
        end
      end

      S_SHIFT: begin
        // read one entry, write the one read last cycle to its new place
        ram_re    = 1'b1;
        ram_raddr = ptr_r;
        ram_we    = wpend_r;
        wpend_nxt = 1'b1;
        waddr_nxt = ins_r ? ptr_r + ADDR_W'(1) : ptr_r - ADDR_W'(1);
        ptr_nxt   = ins_r ? ptr_r - ADDR_W'(1) : ptr_r + ADDR_W'(1);
        if (ptr_r == end_r) state_nxt = S_DRAIN;
      end

      S_DRAIN: begin
        ram_we    = 1'b1;
        state_nxt = ins_r ? S_FILL : S_RESP;
      end

      S_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = end_r;
        ram_wdata = val_r;
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          ld        = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_DUMP_RD: begin
        if (out_free) begin
          ram_re    = 1'b1;
          ram_raddr = ptr_r;
          state_nxt = S_DUMP_LD;
        end
      end

      S_DUMP_LD: begin
        // output register is empty here, it was freed when the read went out
        ld        = 1'b1;
        ld_status = ST_DONE;
        ld_val    = word_out;
        ld_pos    = BPL_POS_W'(ptr_r);
        ld_last   = (ptr_r == end_r);
        if (ptr_r == end_r) begin
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt   = ptr_r + ADDR_W'(1);
          state_nxt = S_DUMP_RD;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = ld ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      wpend_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      wpend_r     <= wpend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    ins_r    <= ins_nxt;
    ptr_r    <= ptr_nxt;
    end_r    <= end_nxt;
    waddr_r  <= waddr_nxt;
    val_r    <= val_nxt;
    if (ld) begin
      out_status_r <= ld_status;
      out_count_r  <= BPL_COUNT_W'(count_r);
      out_val_r    <= ld_val;
      out_pos_r    <= ld_pos;
      out_last_r   <= ld_last;
    end
  end

  bpl_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_pos_r, out_val_r, out_count_r};

endmodule

`default_nettype wire

@@ design/bpl_ram.sv @@
// generic simple dual-port ram, one write port and one registered read port
`timescale 1ns / 1ps
`default_nettype none

module bpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/bpl_checker.sv @@
// port-level checks for the bounded positional list, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module bpl_checker #(
  parameter int CAPACITY = bpl_pkg::BPL_CAPACITY
) (
  input wire logic                                clk,
  input wire logic                                rst_n,
  input wire logic                                out_tvalid,
  input wire logic                                out_tready,
  input wire logic [bpl_pkg::BPL_OUT_TDATA_W-1:0] out_tdata,
  input wire logic [bpl_pkg::BPL_STATUS_W-1:0]    out_tuser,
  input wire logic                                out_tlast
);

  import bpl_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  // only a dump gives more than one result, and those are all done
  a_single_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DONE |-> out_tlast)
    else $error("rejected request gave several results");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[6:0] <= BPL_COUNT_W'(CAPACITY))
    else $error("count beyond capacity");

  // a dumped entry that is not the final one lies below the count
  a_dump_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> BPL_COUNT_W'(out_tdata[20:15]) + 7'd1 < out_tdata[6:0])
    else $error("dump position out of range");

endmodule

bind bounded_positional_list_top bpl_checker #(
  .CAPACITY (CAPACITY)
) u_bpl_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
